[sv/wmi_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wmi_pkg: shared constants of the window median unit
// Default sizes of the sorted store and the sample path, and the width
// of the count field of a result.
// ----------------------------------------------------------------------------
package wmi_pkg;

    localparam int MAX_WINDOW  = 16;
    localparam int SAMPLE_BITS = 16;
    localparam int COUNT_BITS  = 5;

endpackage

[sv/wmi_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wmi_if: channel interfaces of the window median unit
// Sample channel into the unit and result channel out of it, each with a
// valid/ready handshake.
// ----------------------------------------------------------------------------
interface wmi_in_if #(
    parameter int SAMPLE_BITS = wmi_pkg::SAMPLE_BITS
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample;
    logic                          last;

    modport source (output valid, output sample, output last, input ready);
    modport sink   (input valid, input sample, input last, output ready);
endinterface

interface wmi_out_if #(
    parameter int SAMPLE_BITS = wmi_pkg::SAMPLE_BITS
);
    logic                              valid;
    logic                              ready;
    logic signed [SAMPLE_BITS-1:0]     median;
    logic [wmi_pkg::COUNT_BITS-1:0]    count;
    logic                              overflow;

    modport source (output valid, output median, output count, output overflow,
                    input ready);
    modport sink   (input valid, input median, input count, input overflow,
                    output ready);
endinterface

[sv/window_median_int_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// window_median_int_unit: median of a window by insertion sort
// Inserts each signed sample into a sorted store and, on the last sample
// of a window, delivers the median with the sample count and a drop flag.
// ----------------------------------------------------------------------------
//
//  channel   direction  payload                     transfer when
//  i_in      in         sample, last                i_in.valid  & i_in.ready
//  o_out     out        median, count, overflow     o_out.valid & o_out.ready
//
// Steps: a sample joining a store of n entries at position p takes the
// accept step, one read and one compare/shift step per larger entry through
// the single store port, then the placing step: ST_PUT when it lands at the
// bottom (p = 0), otherwise a last read and compare that places it. A
// dropped sample takes only the accept step. The last sample adds two store
// reads and the averaging step, which waits for a free output register.
// Reset empties the store by clearing the fill count; no clearing pass.
// Stalls: i_in.ready is high only while the sequencer is idle. A result
// waits in the output register; the next window may begin meanwhile, and
// only its own result step holds until the register is free.
// ----------------------------------------------------------------------------
module window_median_int_unit #(
    parameter int MAX_WINDOW  = wmi_pkg::MAX_WINDOW,
    parameter int SAMPLE_BITS = wmi_pkg::SAMPLE_BITS
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    wmi_in_if.sink    i_in,
    wmi_out_if.source o_out
);

    // Fill count holds 0..MAX_WINDOW; store index holds 0..MAX_WINDOW-1.
    localparam int CNT_W = $clog2(MAX_WINDOW + 1);
    localparam int IDX_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int CB    = wmi_pkg::COUNT_BITS;

    typedef enum logic [6:0] {
        ST_IDLE = 7'b0000001,   // wait for a sample
        ST_RD   = 7'b0000010,   // read the entry below the hole
        ST_CMP  = 7'b0000100,   // compare, shift up or place
        ST_PUT  = 7'b0001000,   // place at the bottom of the store
        ST_MRD0 = 7'b0010000,   // read the lower middle entry
        ST_MRD1 = 7'b0100000,   // read the upper middle entry
        ST_MSUM = 7'b1000000    // average and hand to the output register
    } t_state;

    // Sorted store: one write port, one registered read port.
    logic signed [SAMPLE_BITS-1:0] r_store [MAX_WINDOW];
    logic signed [SAMPLE_BITS-1:0] r_rdata;

    t_state                        r_state, n_state;
    logic [CNT_W-1:0]              r_fill, n_fill;
    logic                          r_drop, n_drop;
    logic [CNT_W-1:0]              r_pos, n_pos;
    logic signed [SAMPLE_BITS-1:0] r_smp, n_smp;
    logic                          r_last, n_last;
    logic signed [SAMPLE_BITS-1:0] r_lo, n_lo;
    logic                          r_oval, n_oval;
    logic signed [SAMPLE_BITS-1:0] r_omed, n_omed;
    logic [CB-1:0]                 r_ocnt, n_ocnt;
    logic                          r_oovf, n_oovf;

    logic                          w_we;
    logic [IDX_W-1:0]              w_waddr;
    logic signed [SAMPLE_BITS-1:0] w_wdata;
    logic [IDX_W-1:0]              w_raddr;

    logic [CNT_W-1:0]              w_pos_dec;
    logic [CNT_W-1:0]              w_half;
    logic [CNT_W-1:0]              w_lo_idx;
    logic                          w_even;
    logic signed [SAMPLE_BITS:0]   w_sum;
    logic signed [SAMPLE_BITS:0]   w_adj;
    logic signed [SAMPLE_BITS-1:0] w_med;
    logic [CNT_W+CB-1:0]           w_cnt_ext;
    logic                          w_slot_free;
    t_state                        w_after;

    assign w_pos_dec   = r_pos - CNT_W'(1);
    assign w_half      = r_fill >> 1;
    assign w_even      = ~r_fill[0];
    assign w_lo_idx    = w_even ? (w_half - CNT_W'(1)) : w_half;
    assign w_cnt_ext   = {{CB{1'b0}}, r_fill};
    assign w_slot_free = ~r_oval | o_out.ready;
    // After placing a sample: median pass if it closed the window.
    assign w_after     = r_last ? ST_MRD0 : ST_IDLE;

    // Even count: sum one bit wider, halve toward zero (bias negatives by one).
    assign w_sum = {r_lo[SAMPLE_BITS-1], r_lo} + {r_rdata[SAMPLE_BITS-1], r_rdata};
    assign w_adj = w_sum + {{SAMPLE_BITS{1'b0}}, w_sum[SAMPLE_BITS]};
    assign w_med = w_even ? w_adj[SAMPLE_BITS:1] : r_lo;

    assign i_in.ready     = (r_state == ST_IDLE);
    assign o_out.valid    = r_oval;
    assign o_out.median   = r_omed;
    assign o_out.count    = r_ocnt;
    assign o_out.overflow = r_oovf;

    always_comb begin
        n_state = r_state;
        n_fill  = r_fill;
        n_drop  = r_drop;
        n_pos   = r_pos;
        n_smp   = r_smp;
        n_last  = r_last;
        n_lo    = r_lo;
        n_omed  = r_omed;
        n_ocnt  = r_ocnt;
        n_oovf  = r_oovf;
        n_oval  = r_oval & ~o_out.ready;
        w_we    = 1'b0;
        w_waddr = r_pos[IDX_W-1:0];
        w_wdata = r_smp;
        w_raddr = w_pos_dec[IDX_W-1:0];

        case (r_state)
            ST_IDLE: begin
                if (i_in.valid) begin
                    n_smp  = i_in.sample;
                    n_last = i_in.last;
                    n_pos  = r_fill;
                    if (r_fill < CNT_W'(MAX_WINDOW)) begin
                        n_state = (r_fill == '0) ? ST_PUT : ST_RD;
                    end else begin
                        // store full: drop the sample, remember it
                        n_drop  = 1'b1;
                        n_state = i_in.last ? ST_MRD0 : ST_IDLE;
                    end
                end
            end
            ST_RD: begin
                n_state = ST_CMP;
            end
            ST_CMP: begin
                w_we = 1'b1;
                if (r_rdata > r_smp) begin
                    // shift the larger entry up into the hole
                    w_wdata = r_rdata;
                    n_pos   = w_pos_dec;
                    n_state = (w_pos_dec == '0) ? ST_PUT : ST_RD;
                end else begin
                    n_fill  = r_fill + CNT_W'(1);
                    n_state = w_after;
                end
            end
            ST_PUT: begin
                w_we    = 1'b1;
                n_fill  = r_fill + CNT_W'(1);
                n_state = w_after;
            end
            ST_MRD0: begin
                w_raddr = w_lo_idx[IDX_W-1:0];
                n_state = ST_MRD1;
            end
            ST_MRD1: begin
                w_raddr = w_half[IDX_W-1:0];
                n_lo    = r_rdata;
                n_state = ST_MSUM;
            end
            ST_MSUM: begin
                w_raddr = w_half[IDX_W-1:0];
                // hold until the output register is free
                if (w_slot_free) begin
                    n_oval  = 1'b1;
                    n_omed  = w_med;
                    n_ocnt  = w_cnt_ext[CB-1:0];
                    n_oovf  = r_drop;
                    n_fill  = '0;
                    n_drop  = 1'b0;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_store[w_waddr] <= w_wdata;
        end
        r_rdata <= r_store[w_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_fill  <= '0;
            r_drop  <= 1'b0;
            r_oval  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_fill  <= n_fill;
            r_drop  <= n_drop;
            r_oval  <= n_oval;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pos  <= n_pos;
        r_smp  <= n_smp;
        r_last <= n_last;
        r_lo   <= n_lo;
        r_omed <= n_omed;
        r_ocnt <= n_ocnt;
        r_oovf <= n_oovf;
    end

endmodule
